// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held.
`define PFE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pfe check failed");

// Clocked check that also holds through reset.
`define PFE_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("pfe reset check failed");

`endif

// ===== hw/rtl/pfe_pkg.sv =====
`default_nettype none
package pfe_pkg;

    localparam int unsigned NUM_LETTERS  = 26;
    localparam int unsigned NUM_CELLS    = 25;

    localparam logic [4:0] LETTER_I     = 5'd8;
    localparam logic [4:0] LETTER_J     = 5'd9;
    localparam logic [4:0] LETTER_X     = 5'd23;
    localparam logic [4:0] LETTER_LAST  = 5'd25;
    localparam logic [4:0] SQUARE_FULL  = 5'd25;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [6:0] CHAR_UPPER_A = 7'd65;
    localparam logic [2:0] LAST_INDEX   = 3'd4;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_KEY    = 3'd1,
        ACT_FINISH = 3'd2,
        ACT_TEXT   = 3'd3,
        ACT_END    = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_LPA,
        S_LPB,
        S_CALC,
        S_KSA,
        S_OUT0,
        S_KSB,
        S_OUT1
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic clear;
        logic place_key;
        logic walk_start;
        logic walk_step;
        logic hold_set;
        logic digram_text;
        logic digram_end;
        logic lp_sel_b;
        logic lp_cap_a;
        logic lp_cap_b;
        logic ks_sel_second;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic    in_accept;
        t_action action;
        logic    is_letter;
        logic    key_placed;
        logic    complete;
        logic    held_valid;
        logic    walk_last;
        logic    out_free;
    } t_status;

    // next index around a row or column of the square
    function automatic logic [2:0] wrap_inc(input logic [2:0] idx);
        return (idx == LAST_INDEX) ? 3'd0 : idx + 3'd1;
    endfunction

    function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pfe_in_if.sv =====
`default_nettype none
interface pfe_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] char_in;

    modport source (output valid, output action, output char_in, input ready);
    modport sink   (input valid, input action, input char_in, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pfe_out_if.sv =====
`default_nettype none
interface pfe_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] cipher_char;
    logic       pair_end;

    modport source (output valid, output cipher_char, output pair_end, input ready);
    modport sink   (input valid, input cipher_char, input pair_end, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pfe_ram.sv =====
`default_nettype none
module pfe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hw/rtl/pfe_ctrl.sv =====
`default_nettype none
module pfe_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pfe_pkg::t_status i_status,
    output      pfe_pkg::t_cmd    o_cmd
);

    pfe_pkg::t_state r_state;
    pfe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            pfe_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_accept) begin
                    n_state = pfe_pkg::S_DECODE;
                end
            end
            pfe_pkg::S_DECODE: begin
                n_state = pfe_pkg::S_IDLE;
                unique case (i_status.action)
                    pfe_pkg::ACT_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    pfe_pkg::ACT_KEY: begin
                        o_cmd.place_key = i_status.is_letter && !i_status.key_placed &&
                                          !i_status.complete;
                    end
                    pfe_pkg::ACT_FINISH: begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = pfe_pkg::S_WALK;
                    end
                    pfe_pkg::ACT_TEXT: begin
                        if (i_status.complete && i_status.is_letter) begin
                            if (!i_status.held_valid) begin
                                o_cmd.hold_set = 1'b1;
                            end else begin
                                o_cmd.digram_text = 1'b1;
                                n_state           = pfe_pkg::S_LPA;
                            end
                        end
                    end
                    pfe_pkg::ACT_END: begin
                        if (i_status.complete && i_status.held_valid) begin
                            o_cmd.digram_end = 1'b1;
                            n_state          = pfe_pkg::S_LPA;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            pfe_pkg::S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_last) begin
                    n_state = pfe_pkg::S_IDLE;
                end
            end
            pfe_pkg::S_LPA: begin
                n_state = pfe_pkg::S_LPB;
            end
            pfe_pkg::S_LPB: begin
                o_cmd.lp_sel_b = 1'b1;
                o_cmd.lp_cap_a = 1'b1;
                n_state        = pfe_pkg::S_CALC;
            end
            pfe_pkg::S_CALC: begin
                o_cmd.lp_cap_b = 1'b1;
                n_state        = pfe_pkg::S_KSA;
            end
            pfe_pkg::S_KSA: begin
                n_state = pfe_pkg::S_OUT0;
            end
            pfe_pkg::S_OUT0: begin
                // hold the read address until the output slot frees up
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = pfe_pkg::S_KSB;
                end
            end
            pfe_pkg::S_KSB: begin
                o_cmd.ks_sel_second = 1'b1;
                n_state             = pfe_pkg::S_OUT1;
            end
            pfe_pkg::S_OUT1: begin
                o_cmd.ks_sel_second = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = pfe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfe_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pfe_datapath.sv =====
`default_nettype none
module pfe_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pfe_pkg::t_cmd    i_cmd,
    output      pfe_pkg::t_status o_status,
    input  wire logic             i_in_valid,
    input  wire logic [2:0]       i_action,
    input  wire logic [7:0]       i_char_in,
    output      logic             o_out_valid,
    input  wire logic             i_out_ready,
    output      logic [6:0]       o_cipher_char,
    output      logic             o_pair_end
);

    // latched request
    logic [2:0] r_action;
    logic [4:0] r_letter;
    logic       r_is_letter;

    // key square bookkeeping
    logic [pfe_pkg::NUM_LETTERS-1:0] r_placed;
    logic [4:0] r_fill;
    logic [2:0] r_fill_row;
    logic [2:0] r_fill_col;
    logic [4:0] r_walk;

    logic       r_held_valid;
    logic [4:0] r_held_letter;

    // digram operands and their square positions {row, col}
    logic [4:0] r_a;
    logic [4:0] r_b;
    logic [5:0] r_pa;
    logic [5:0] r_pb;

    logic       r_out_valid;
    logic [6:0] r_out_char;
    logic       r_out_end;

    logic       in_accept;
    logic       char_is_letter;
    logic [4:0] char_letter;
    logic       complete;
    logic       walk_place;
    logic       place_en;
    logic [4:0] place_letter;
    logic [5:0] lp_rdata;
    logic [4:0] ks_rdata;
    logic [4:0] lp_raddr;
    logic [4:0] ks_raddr;
    logic [4:0] addr0;
    logic [4:0] addr1;
    logic [2:0] ra, ca, rb, cb;
    logic       out_free;

    assign in_accept      = i_in_valid && i_cmd.in_ready;
    assign char_is_letter = (i_char_in >= pfe_pkg::CHAR_LOWER_A) &&
                            (i_char_in <= pfe_pkg::CHAR_LOWER_Z);

    always_comb begin
        char_letter = 5'd0;
        if (char_is_letter) begin
            char_letter = 5'(i_char_in - pfe_pkg::CHAR_LOWER_A);
            if (char_letter == pfe_pkg::LETTER_I) begin
                char_letter = pfe_pkg::LETTER_J;
            end
        end
    end

    assign complete   = (r_fill == pfe_pkg::SQUARE_FULL);
    assign walk_place = i_cmd.walk_step && (r_walk != pfe_pkg::LETTER_I) &&
                        !r_placed[r_walk] && !complete;
    assign place_en     = i_cmd.place_key || walk_place;
    assign place_letter = i_cmd.place_key ? r_letter : r_walk;
    assign out_free     = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action    <= i_action;
            r_letter    <= char_letter;
            r_is_letter <= char_is_letter;
        end
        if (i_cmd.walk_start) begin
            r_walk <= 5'd0;
        end else if (i_cmd.walk_step) begin
            r_walk <= r_walk + 5'd1;
        end
        if (i_cmd.digram_text) begin
            r_a <= r_held_letter;
            r_b <= (r_letter == r_held_letter) ? pfe_pkg::LETTER_X : r_letter;
        end else if (i_cmd.digram_end) begin
            r_a <= r_held_letter;
            r_b <= pfe_pkg::LETTER_X;
        end
        if (i_cmd.lp_cap_a) begin
            r_pa <= lp_rdata;
        end
        if (i_cmd.lp_cap_b) begin
            r_pb <= lp_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_char <= 7'(ks_rdata) + pfe_pkg::CHAR_UPPER_A;
            r_out_end  <= i_cmd.ks_sel_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_placed      <= '0;
            r_fill        <= 5'd0;
            r_fill_row    <= 3'd0;
            r_fill_col    <= 3'd0;
            r_held_valid  <= 1'b0;
            r_held_letter <= 5'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_placed      <= '0;
                r_fill        <= 5'd0;
                r_fill_row    <= 3'd0;
                r_fill_col    <= 3'd0;
                r_held_valid  <= 1'b0;
                r_held_letter <= 5'd0;
            end else if (place_en) begin
                r_placed[place_letter] <= 1'b1;
                r_fill                 <= r_fill + 5'd1;
                if (r_fill_col == pfe_pkg::LAST_INDEX) begin
                    r_fill_col <= 3'd0;
                    r_fill_row <= r_fill_row + 3'd1;
                end else begin
                    r_fill_col <= r_fill_col + 3'd1;
                end
            end
            if (i_cmd.hold_set) begin
                r_held_valid  <= 1'b1;
                r_held_letter <= r_letter;
            end else if ((i_cmd.digram_text && (r_letter != r_held_letter)) ||
                         i_cmd.digram_end) begin
                r_held_valid  <= 1'b0;
                r_held_letter <= 5'd0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // row, column and rectangle rules
    assign ra = r_pa[5:3];
    assign ca = r_pa[2:0];
    assign rb = r_pb[5:3];
    assign cb = r_pb[2:0];

    always_comb begin
        if (ra == rb) begin
            addr0 = pfe_pkg::cell_addr(ra, pfe_pkg::wrap_inc(ca));
            addr1 = pfe_pkg::cell_addr(rb, pfe_pkg::wrap_inc(cb));
        end else if (ca == cb) begin
            addr0 = pfe_pkg::cell_addr(pfe_pkg::wrap_inc(ra), ca);
            addr1 = pfe_pkg::cell_addr(pfe_pkg::wrap_inc(rb), cb);
        end else begin
            addr0 = pfe_pkg::cell_addr(ra, cb);
            addr1 = pfe_pkg::cell_addr(rb, ca);
        end
    end

    assign lp_raddr = i_cmd.lp_sel_b ? r_b : r_a;
    assign ks_raddr = i_cmd.ks_sel_second ? addr1 : addr0;

    pfe_ram #(
        .WIDTH (6),
        .DEPTH (pfe_pkg::NUM_LETTERS)
    ) u_letter_place (
        .i_clk   (i_clk),
        .i_we    (place_en),
        .i_waddr (place_letter),
        .i_wdata ({r_fill_row, r_fill_col}),
        .i_raddr (lp_raddr),
        .o_rdata (lp_rdata)
    );

    pfe_ram #(
        .WIDTH (5),
        .DEPTH (pfe_pkg::NUM_CELLS)
    ) u_key_square (
        .i_clk   (i_clk),
        .i_we    (place_en),
        .i_waddr (r_fill),
        .i_wdata (place_letter),
        .i_raddr (ks_raddr),
        .o_rdata (ks_rdata)
    );

    always_comb begin
        o_status            = '0;
        o_status.in_accept  = in_accept;
        o_status.action     = pfe_pkg::t_action'(r_action);
        o_status.is_letter  = r_is_letter;
        o_status.key_placed = r_placed[r_letter];
        o_status.complete   = complete;
        o_status.held_valid = r_held_valid;
        o_status.walk_last  = (r_walk == pfe_pkg::LETTER_LAST);
        o_status.out_free   = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_cipher_char = r_out_char;
    assign o_pair_end    = r_out_end;

endmodule
`default_nettype wire

// ===== hw/rtl/playfair_digram_encrypt.sv =====
// A clear, key byte, skipped text byte or a text byte that only gets held is acted on in S_DECODE.
// Finish key: the fill walk in S_WALK visits one letter of the alphabet per cycle.
// A request that closes a digram reads the letter table for each letter (S_LPA, S_LPB, S_CALC),
// then the key square for each cipher letter (S_KSA, S_OUT0, S_KSB, S_OUT1); each cipher letter
// waits for a free output slot, and the next request is taken after the second one is loaded.
// Reset clears the key, the placements, the held letter and the output; no clearing pass.
`default_nettype none
module playfair_digram_encrypt (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pfe_in_if.sink    i_req,
    pfe_out_if.source o_rsp
);

    pfe_pkg::t_cmd    cmd;
    pfe_pkg::t_status status;

    pfe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pfe_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_valid    (i_req.valid),
        .i_action      (i_req.action),
        .i_char_in     (i_req.char_in),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_cipher_char (o_rsp.cipher_char),
        .o_pair_end    (o_rsp.pair_end)
    );

    assign i_req.ready = cmd.in_ready;

endmodule
`default_nettype wire

// ===== hw/rtl/pfe_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module pfe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [6:0] i_cipher_char,
    input wire logic       i_pair_end
);

    `PFE_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cipher_char) && $stable(i_pair_end))
    `PFE_ASSERT(a_upper_letter, i_out_valid |-> (i_cipher_char >= 7'd65) && (i_cipher_char <= 7'd90))
    // the first letter of a digram pending means the second is still being produced
    `PFE_ASSERT(a_busy_mid_pair, i_out_valid && !i_pair_end |-> !i_in_ready)
    `PFE_ASSERT(a_no_accept_mid_pair, i_in_valid && i_in_ready |-> !(i_out_valid && !i_pair_end))
    `PFE_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !i_out_valid)

endmodule

bind playfair_digram_encrypt pfe_checker u_pfe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_cipher_char (o_rsp.cipher_char),
    .i_pair_end    (o_rsp.pair_end)
);
`default_nettype wire
